// File: rtl/bicubic_patch_evaluator_unit_assert.svh
// assertion macros for the bicubic patch evaluator checker
// expects clk and arst_n in the scope of use
`ifndef BICUBIC_PATCH_EVALUATOR_UNIT_ASSERT_SVH
`define BICUBIC_PATCH_EVALUATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BPE_ASSERT_IMP(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("bpe check failed");

// next-cycle implication
`define BPE_ASSERT_NXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("bpe check failed");

`endif

// File: rtl/bpe_pkg.sv
// shared types, codes and the fixed-point lerp for the bicubic patch evaluator
// no dependencies
package bpe_pkg;

	localparam int CW    = 32;
	localparam int IDX_W = 4;
	localparam int PW    = 17;
	localparam int FRAC  = 16;

	localparam logic [PW-1:0] PARAM_ONE = 17'd65536;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		logic              cmd;
		logic [IDX_W-1:0]  point_index;
		coord_t            coord_x;
		coord_t            coord_y;
		coord_t            coord_z;
		logic [PW-1:0]     param_u;
		logic [PW-1:0]     param_v;
	} req_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
	} res_t;

	// control that travels beside each row of the stream
	typedef struct packed {
		logic          vld;
		logic          last;
		logic [PW-1:0] u;
	} pipe_ctl_t;

	// a + floor((b - a) * t / 2^16)
	function automatic coord_t lerp(coord_t a, coord_t b, logic [PW-1:0] t);
		logic signed [CW:0]      d;
		logic signed [CW+PW+1:0] p;
		begin
			d = {b[CW-1], b} - {a[CW-1], a};
			p = d * $signed({1'b0, t});
			return a + p[FRAC+CW-1:FRAC];
		end
	endfunction

	function automatic point_t lerp_pt(point_t a, point_t b, logic [PW-1:0] t);
		point_t r;
		begin
			r.x = lerp(a.x, b.x, t);
			r.y = lerp(a.y, b.y, t);
			r.z = lerp(a.z, b.z, t);
			return r;
		end
	endfunction

endpackage

// File: rtl/bpe_store.sv
// control point store, one memory per grid column, read one row per cycle while rd_en is high
// depends on bpe_pkg
module bpe_store #(
	parameter int PATCH_SIDE = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [bpe_pkg::IDX_W-1:0]      wr_idx,
	input  bpe_pkg::point_t                wr_pt,
	input  logic                           rd_en,
	input  logic [$clog2(PATCH_SIDE)-1:0]  rd_row,
	output bpe_pkg::point_t                rd_pts [PATCH_SIDE]
);
	import bpe_pkg::*;

	localparam int RW    = $clog2(PATCH_SIDE);
	localparam int SLOTS = PATCH_SIDE * PATCH_SIDE;

	logic          wr_ok;
	logic [RW-1:0] wr_row;
	logic [RW-1:0] wr_col;

	assign wr_ok = wr_en && (int'(wr_idx) < SLOTS);

	// split the slot into row and column by compares against row starts
	always_comb begin
		wr_row = '0;
		wr_col = wr_idx[RW-1:0];
		for (int r = 1; r < PATCH_SIDE; r++) begin
			if (int'(wr_idx) >= r * PATCH_SIDE) begin
				wr_row = RW'(r);
				wr_col = RW'(int'(wr_idx) - r * PATCH_SIDE);
			end
		end
	end

	for (genvar c = 0; c < PATCH_SIDE; c++) begin : g_col
		point_t                mem [PATCH_SIDE];
		logic [PATCH_SIDE-1:0] vld_q;
		logic                  wr_here;

		assign wr_here = wr_ok && (wr_col == RW'(c));

		// entries never written read as zero
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q <= '0;
			end else if (wr_here) begin
				vld_q[wr_row] <= 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (wr_here) begin
				mem[wr_row] <= wr_pt;
			end
			if (rd_en) begin
				rd_pts[c] <= vld_q[rd_row] ? mem[rd_row] : '0;
			end
		end
	end

endmodule

// File: rtl/bpe_row_reduce.sv
// pipelined de casteljau triangle that reduces one grid row at v per cycle while adv is high
// depends on bpe_pkg
module bpe_row_reduce #(
	parameter int PATCH_SIDE = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  bpe_pkg::point_t             in_pts [PATCH_SIDE],
	input  bpe_pkg::pipe_ctl_t          in_ctl,
	input  logic [bpe_pkg::PW-1:0]      in_v,
	output bpe_pkg::point_t             out_pt,
	output bpe_pkg::pipe_ctl_t          out_ctl
);
	import bpe_pkg::*;

	localparam int LV = PATCH_SIDE - 1;

	point_t        lvl_q [LV][PATCH_SIDE];
	pipe_ctl_t     ctl_q [LV];
	logic [PW-1:0] v_q   [LV];

	point_t        src   [LV][PATCH_SIDE];
	pipe_ctl_t     src_c [LV];
	logic [PW-1:0] src_v [LV];

	always_comb begin
		for (int l = 0; l < LV; l++) begin
			for (int j = 0; j < PATCH_SIDE; j++) begin
				src[l][j] = (l == 0) ? in_pts[j] : lvl_q[(l == 0) ? 0 : l-1][j];
			end
			src_c[l] = (l == 0) ? in_ctl : ctl_q[(l == 0) ? 0 : l-1];
			src_v[l] = (l == 0) ? in_v : v_q[(l == 0) ? 0 : l-1];
		end
	end

	// lanes past the live width of a level are never used; the last lane just repeats its input
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LV; l++) begin
				for (int j = 0; j < PATCH_SIDE; j++) begin
					lvl_q[l][j] <= lerp_pt(src[l][j],
						src[l][(j + 1 < PATCH_SIDE) ? j + 1 : j], src_v[l]);
				end
				v_q[l] <= src_v[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LV; l++) begin
				ctl_q[l] <= '0;
			end
		end else if (adv) begin
			for (int l = 0; l < LV; l++) begin
				ctl_q[l] <= src_c[l];
			end
		end
	end

	assign out_pt  = lvl_q[LV-1][0];
	assign out_ctl = ctl_q[LV-1];

endmodule

// File: rtl/bpe_cell.sv
// one cell of the u chain: lerps each arriving row result with the one before it
// depends on bpe_pkg
module bpe_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  bpe_pkg::point_t    in_pt,
	input  bpe_pkg::pipe_ctl_t in_ctl,
	output bpe_pkg::point_t    out_pt,
	output bpe_pkg::pipe_ctl_t out_ctl
);
	import bpe_pkg::*;

	point_t    prev_q;
	point_t    pt_q;
	pipe_ctl_t ctl_q;

	always_ff @(posedge clk) begin
		if (adv && in_ctl.vld) begin
			prev_q <= in_pt;
			pt_q   <= lerp_pt(prev_q, in_pt, in_ctl.u);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= in_ctl;
		end
	end

	assign out_pt  = pt_q;
	assign out_ctl = ctl_q;

endmodule

// File: rtl/bicubic_patch_evaluator_unit.sv
// bicubic bezier patch evaluator, de casteljau over a PATCH_SIDE x PATCH_SIDE grid
// load request: written into the store at acceptance
// evaluate request: one store row read per cycle while no finished result is held; the rows pass
// the row reduce levels, u chain cells and output register; evaluates overlap back to back
// reset: store reads as all zeros, sequencer idle, no result pending
// depends on bpe_pkg, bpe_store, bpe_row_reduce, bpe_cell
module bicubic_patch_evaluator_unit #(
	parameter int PATCH_SIDE = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bpe_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output bpe_pkg::res_t res
);
	import bpe_pkg::*;

	localparam int RW = $clog2(PATCH_SIDE);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} st_t;

	// sequencer
	st_t           st_q;
	logic [RW-1:0] cnt_q;
	logic [PW-1:0] u_q;
	logic [PW-1:0] v_q;

	logic          adv;
	logic          last_rd;
	logic          acc;
	logic          eval_acc;
	logic          load_acc;
	logic [PW-1:0] u_sat;
	logic [PW-1:0] v_sat;

	// stream
	point_t        rd_pts [PATCH_SIDE];
	pipe_ctl_t     ctl_s1;
	logic [PW-1:0] v_s1;
	point_t        wr_pt;
	point_t        ch_pt  [PATCH_SIDE];
	pipe_ctl_t     ch_ctl [PATCH_SIDE];

	// output register
	logic res_vld_q;
	res_t res_q;

	// the whole stream moves unless a finished result is being held
	assign adv     = !res_vld_q || res_ready;
	assign last_rd = (st_q == ST_READ) && (cnt_q == RW'(PATCH_SIDE - 1)) && adv;

	// a new request may land in the cycle of the last row read
	assign req_ready = (st_q == ST_IDLE) || last_rd;
	assign acc       = req_valid && req_ready;
	assign eval_acc  = acc && (req.cmd == CMD_EVAL);
	assign load_acc  = acc && (req.cmd == CMD_LOAD);

	// parameters above one clamp to one
	assign u_sat = (req.param_u > PARAM_ONE) ? PARAM_ONE : req.param_u;
	assign v_sat = (req.param_v > PARAM_ONE) ? PARAM_ONE : req.param_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (eval_acc) begin
						st_q  <= ST_READ;
						cnt_q <= '0;
					end
				end
				ST_READ: begin
					if (adv) begin
						if (cnt_q == RW'(PATCH_SIDE - 1)) begin
							st_q  <= eval_acc ? ST_READ : ST_IDLE;
							cnt_q <= '0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: begin
					st_q  <= ST_IDLE;
					cnt_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (eval_acc) begin
			u_q <= u_sat;
			v_q <= v_sat;
		end
	end

	assign wr_pt.x = req.coord_x;
	assign wr_pt.y = req.coord_y;
	assign wr_pt.z = req.coord_z;

	bpe_store #(
		.PATCH_SIDE(PATCH_SIDE)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (load_acc),
		.wr_idx (req.point_index),
		.wr_pt  (wr_pt),
		.rd_en  (adv),
		.rd_row (cnt_q),
		.rd_pts (rd_pts)
	);

	// control aligned with the registered row read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.vld  <= (st_q == ST_READ);
			ctl_s1.last <= (cnt_q == RW'(PATCH_SIDE - 1));
			ctl_s1.u    <= u_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1 <= v_q;
		end
	end

	// each row collapses to one point at v
	bpe_row_reduce #(
		.PATCH_SIDE(PATCH_SIDE)
	) u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_pts  (rd_pts),
		.in_ctl  (ctl_s1),
		.in_v    (v_s1),
		.out_pt  (ch_pt[0]),
		.out_ctl (ch_ctl[0])
	);

	// row results stream through the u chain; the last cell holds the
	// surface point when the last row of a request leaves it
	for (genvar k = 0; k < PATCH_SIDE - 1; k++) begin : g_chain
		bpe_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.in_pt   (ch_pt[k]),
			.in_ctl  (ch_ctl[k]),
			.out_pt  (ch_pt[k+1]),
			.out_ctl (ch_ctl[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= ch_ctl[PATCH_SIDE-1].vld && ch_ctl[PATCH_SIDE-1].last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ch_ctl[PATCH_SIDE-1].vld && ch_ctl[PATCH_SIDE-1].last) begin
			res_q.point_x <= ch_pt[PATCH_SIDE-1].x;
			res_q.point_y <= ch_pt[PATCH_SIDE-1].y;
			res_q.point_z <= ch_pt[PATCH_SIDE-1].z;
		end
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

endmodule

// File: rtl/bpe_checker.sv
// port-level checks for the bicubic patch evaluator, bound to the top level
// depends on bpe_pkg and bicubic_patch_evaluator_unit_assert.svh
`include "bicubic_patch_evaluator_unit_assert.svh"

module bpe_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input bpe_pkg::req_t req,
	input logic          res_valid,
	input logic          res_ready,
	input bpe_pkg::res_t res
);
	import bpe_pkg::*;

	// a held result keeps its value
	`BPE_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))
	// an evaluate occupies the row reader in the next cycle
	`BPE_ASSERT_NXT(a_eval_busy, req_valid && req_ready && req.cmd == CMD_EVAL, !req_ready)
	// a load never blocks the next request
	`BPE_ASSERT_NXT(a_load_free, req_valid && req_ready && req.cmd == CMD_LOAD, req_ready)

endmodule

bind bicubic_patch_evaluator_unit bpe_checker u_bpe_checker (.*);
